/* rtl/bba_pkg.sv */
// Package for the bitmap block allocator: sizes, codes and payload types.
`timescale 1ns / 1ps
package bba_pkg;

  localparam int NUM_BLOCKS = 4096;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = $clog2(MAP_WORDS);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int BLK_W      = 12;
  localparam int CNT_W      = 13;

  typedef enum logic [1:0] {
    FN_ALLOC      = 2'd0,
    FN_FREE       = 2'd1,
    FN_MARK_RANGE = 2'd2,
    FN_FREE_RANGE = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [BLK_W-1:0]   block_number;
    logic [CNT_W-1:0]   block_count;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0]   alloc_block;
    logic               status;
    logic [CNT_W-1:0]   used_count;
    logic [CNT_W-1:0]   free_count;
  } out_item_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic [WORD_AW-1:0]   addr;
    logic [WORD_BITS-1:0] wdata;
  } map_req_t;

endpackage

/* rtl/bitmap_block_allocator_top.sv */
// Bitmap block allocator: first-fit allocate, free and range mark/free over a word bitmap.
//
// Input channel in_valid_i/in_ready_o carries one request (func, block_number,
// block_count). Each request gives exactly one result on out_valid_o/out_ready_i:
// allocated block, status (1 = no free block), used count and free count.
// cfg_valid_i/cfg_ready_o writes total_blocks; write it only while the block is idle.
// One request is worked on at a time; in_ready_o is high when the sequencer is idle.
// The bitmap lives in a 64 x 64-bit single-port RAM; every word touched is read,
// then modified and written back, but a full word passed over by the scan is only read.
// Allocate reads words from word 0 up until one has a clear bit, or the scan runs out;
// free one touches a single word; a range touches each bitmap word it covers.
// in_ready_o rises in the same cycle as out_valid_o.
// The result sits in an output register; the next request is taken while it waits.
// If the receiver stalls and a second result is ready, the sequencer holds in its
// final state until the output register empties.
// Reset: bitmap all free (per-word valid flags, no clearing pass), used count 0,
// total_blocks 4096.
`timescale 1ns / 1ps
module bitmap_block_allocator_top
  import bba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_MOD,
    S_RNG_RD,
    S_RNG_MOD,
    S_DONE
  } state_e;

  localparam logic [CNT_W-1:0]   NumBlk   = CNT_W'(NUM_BLOCKS);
  localparam logic [BIT_AW:0]    WordBits = (BIT_AW + 1)'(WORD_BITS);

  state_e               state_q, state_d;
  logic [WORD_AW:0]     w_q, w_d;
  logic [CNT_W-1:0]     cur_q, cur_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic                 set_q, set_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [CNT_W-1:0]     total_q, total_d;
  logic [BLK_W-1:0]     given_q, given_d;
  logic                 stat_q, stat_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  map_req_t             req;
  logic [WORD_BITS-1:0] word;
  logic [CNT_W-1:0]     lim;
  logic [CNT_W-1:0]     free_now;

  // first clear bit of the word, two levels of eight
  logic [WORD_BITS-1:0] zmask;
  logic [7:0]           byte_hit;
  logic [2:0]           byte_sel;
  logic [7:0]           sel_byte;
  logic [2:0]           bit_sel;
  logic [BIT_AW-1:0]    zero_pos;

  // range step within one word
  logic [BIT_AW-1:0]    lo;
  logic [BIT_AW:0]      space;
  logic [BIT_AW:0]      n;
  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] rmask;
  logic [CNT_W:0]       up_sum;
  logic [CNT_W-1:0]     cur_next;
  logic [BLK_W-1:0]     found_idx;
  logic [CNT_W-1:0]     scan_base;

  bba_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (word)
  );

  assign lim      = (total_q > NumBlk) ? NumBlk : total_q;
  assign free_now = (used_q >= lim) ? '0 : lim - used_q;

  always_comb begin
    zmask    = ~word;
    byte_sel = '0;
    bit_sel  = '0;
    for (int j = 0; j < 8; j++) begin
      byte_hit[j] = |zmask[8*j +: 8];
    end
    for (int j = 7; j >= 0; j--) begin
      if (byte_hit[j]) byte_sel = 3'(j);
    end
    sel_byte = zmask[8*byte_sel +: 8];
    for (int j = 7; j >= 0; j--) begin
      if (sel_byte[j]) bit_sel = 3'(j);
    end
    zero_pos = {byte_sel, bit_sel};
  end

  assign found_idx = {w_q[WORD_AW-1:0], zero_pos};
  assign scan_base = {w_q, {BIT_AW{1'b0}}};

  assign lo    = cur_q[BIT_AW-1:0];
  assign space = WordBits - {1'b0, lo};
  assign n     = (rem_q < CNT_W'(space)) ? rem_q[BIT_AW:0] : space;
  assign ones  = (n == WordBits) ? '1 : ((WORD_BITS'(1) << n) - WORD_BITS'(1));
  assign rmask = ones << lo;
  assign up_sum   = {1'b0, used_q} + (CNT_W + 1)'(n);
  assign cur_next = cur_q + CNT_W'(n);

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    set_d       = set_q;
    used_d      = used_q;
    total_d     = total_q;
    given_d     = given_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    req         = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      total_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          given_d = '0;
          stat_d  = 1'b0;
          w_d     = '0;
          cur_d   = {1'b0, in_data_i.block_number};
          if (in_data_i.func == FN_FREE || in_data_i.block_count == '0) begin
            rem_d = CNT_W'(1);
          end else begin
            rem_d = in_data_i.block_count;
          end
          set_d   = (in_data_i.func == FN_MARK_RANGE);
          state_d = (in_data_i.func == FN_ALLOC) ? S_SCAN_RD : S_RNG_RD;
        end
      end
      S_SCAN_RD: begin
        if (free_now == '0 || w_q[WORD_AW] || scan_base >= lim) begin
          stat_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          req.rd_en = 1'b1;
          req.addr  = w_q[WORD_AW-1:0];
          state_d   = S_SCAN_MOD;
        end
      end
      S_SCAN_MOD: begin
        if (&word) begin
          w_d     = w_q + 1'b1;
          state_d = S_SCAN_RD;
        end else if ({1'b0, found_idx} >= lim) begin
          stat_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          req.wr_en = 1'b1;
          req.addr  = w_q[WORD_AW-1:0];
          req.wdata = word | (WORD_BITS'(1) << zero_pos);
          if (used_q < NumBlk) used_d = used_q + 1'b1;
          given_d   = found_idx;
          state_d   = S_DONE;
        end
      end
      S_RNG_RD: begin
        req.rd_en = 1'b1;
        req.addr  = cur_q[BIT_AW +: WORD_AW];
        state_d   = S_RNG_MOD;
      end
      S_RNG_MOD: begin
        req.wr_en = 1'b1;
        req.addr  = cur_q[BIT_AW +: WORD_AW];
        if (set_q) begin
          req.wdata = word | rmask;
          used_d    = (up_sum > {1'b0, NumBlk}) ? NumBlk : up_sum[CNT_W-1:0];
        end else begin
          req.wdata = word & ~rmask;
          used_d    = (used_q > CNT_W'(n)) ? used_q - CNT_W'(n) : '0;
        end
        cur_d = cur_next;
        rem_d = rem_q - CNT_W'(n);
        // stop at end of count or end of storage
        if (rem_q == CNT_W'(n) || cur_next >= NumBlk) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RNG_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_d.alloc_block      = given_q;
          out_d.status           = stat_q;
          out_d.used_count       = used_q;
          out_d.free_count       = free_now;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      w_q         <= '0;
      cur_q       <= '0;
      rem_q       <= '0;
      set_q       <= 1'b0;
      used_q      <= '0;
      total_q     <= NumBlk;
      given_q     <= '0;
      stat_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      cur_q       <= cur_d;
      rem_q       <= rem_d;
      set_q       <= set_d;
      used_q      <= used_d;
      total_q     <= total_d;
      given_q     <= given_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.used_count <= NumBlk)
    else $error("used count above storage size");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.alloc_block == '0)
    else $error("failed allocate returned a block");

  a_free_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.free_count != '0 |->
      out_data_o.free_count + out_data_o.used_count == lim)
    else $error("free and used counts disagree with limit");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.wr_en |-> !req.rd_en)
    else $error("map read and write in one cycle");

  a_scan_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN_MOD && !(&word) |=> state_q == S_DONE)
    else $error("scan did not finish on a word with a free bit");
`endif

endmodule

/* rtl/bba_ram.sv */
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bba_map.sv */
// Usage bitmap store: word RAM plus per-word valid flags so reset reads as all free.
`timescale 1ns / 1ps
module bba_map
  import bba_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  map_req_t             req_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [MAP_WORDS-1:0] vld_q;
  logic                 rd_vld_q;
  logic [WORD_BITS-1:0] ram_rdata;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (req_i.rd_en | req_i.wr_en),
    .we_i    (req_i.wr_en),
    .addr_i  (req_i.addr),
    .wdata_i (req_i.wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end else if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  // never-written words read as free
  assign rdata_o = rd_vld_q ? ram_rdata : '0;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the bitmap block allocator: random handshakes, predicted results.
`timescale 1ns / 1ps
module tb_top;
  import bba_pkg::*;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i  = '0;

  bitmap_block_allocator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // mirror of the allocator state
  bit          usage_map [NUM_BLOCKS];
  int unsigned used_blocks_q  = 0;
  int unsigned total_blocks_q = NUM_BLOCKS;

  in_item_t    pending_reqs [$];
  out_item_t   expected_results [$];
  out_item_t   result_want;
  int unsigned accepted_reqs = 0;
  int unsigned mismatches    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned managed_limit();
    return (total_blocks_q > NUM_BLOCKS) ? NUM_BLOCKS : total_blocks_q;
  endfunction

  function automatic int unsigned blocks_left();
    return (used_blocks_q >= managed_limit()) ? 0 : managed_limit() - used_blocks_q;
  endfunction

  // counter moves on every block touched, changed or not
  function automatic void mark_block(int unsigned idx, bit set);
    usage_map[idx] = set;
    if (set && used_blocks_q < NUM_BLOCKS)
      used_blocks_q++;
    else if (!set && used_blocks_q > 0)
      used_blocks_q--;
  endfunction

  function automatic out_item_t next_result(in_item_t req);
    out_item_t   res;
    int unsigned lim;
    int unsigned span_cnt;
    int unsigned idx;
    bit          hit;
    res = '0;
    lim = managed_limit();
    span_cnt = (req.block_count == 0) ? 1 : req.block_count;
    case (req.func)
      FN_ALLOC: begin
        hit = 1'b0;
        idx = 0;
        // first fit: lowest clear bit below the managed limit
        if (blocks_left() != 0) begin
          for (int unsigned b = 0; b < lim && !hit; b++) begin
            if (!usage_map[b]) begin
              hit = 1'b1;
              idx = b;
            end
          end
        end
        if (hit) begin
          mark_block(idx, 1'b1);
          res.alloc_block = BLK_W'(idx);
        end else begin
          res.status = 1'b1;
        end
      end
      FN_FREE: mark_block(req.block_number, 1'b0);
      default: begin
        // a range stops at the end of storage
        for (int unsigned i = 0; i < span_cnt; i++) begin
          idx = req.block_number + i;
          if (idx >= NUM_BLOCKS)
            break;
          mark_block(idx, req.func == FN_MARK_RANGE);
        end
      end
    endcase
    res.used_count = CNT_W'(used_blocks_q);
    res.free_count = CNT_W'(blocks_left());
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_req(func_e f, int unsigned bn, int unsigned bc);
    in_item_t r;
    r.func         = f;
    r.block_number = BLK_W'(bn);
    r.block_count  = CNT_W'(bc);
    pending_reqs.push_back(r);
  endtask

  function automatic in_item_t random_req(int unsigned span);
    in_item_t    r;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    r.block_number = ($urandom_range(99) < 85) ? BLK_W'($urandom_range(span)) : BLK_W'($urandom);
    if (sel < 80)
      r.block_count = CNT_W'($urandom_range(8));
    else if (sel < 95)
      r.block_count = CNT_W'($urandom_range(130, 9));
    else
      r.block_count = CNT_W'($urandom_range(8191));
    if (pick < 45)
      r.func = FN_ALLOC;
    else if (pick < 65)
      r.func = FN_FREE;
    else if (pick < 80)
      r.func = FN_MARK_RANGE;
    else if (pick < 95)
      r.func = FN_FREE_RANGE;
    else begin
      r.func         = func_e'(2'($urandom));
      r.block_number = BLK_W'($urandom);
      r.block_count  = CNT_W'($urandom);
    end
    return r;
  endfunction

  // idle: nothing queued, nothing offered, nothing outstanding, then let the sequencer settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned blocks, int unsigned n);
    int unsigned span;
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= CNT_W'(blocks);
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    total_blocks_q  = blocks;
    span = (blocks < 280) ? blocks + 16 : 300;
    repeat (n) pending_reqs.push_back(random_req(span));
  endtask

  // driver: predicts on each accepted transfer, refills the input slot from the queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(next_result(in_data_i));
        accepted_reqs <= accepted_reqs + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_reqs.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once, while the sender keeps offering
  always @(posedge clk_i) begin
    if (hold_left != 0)
      hold_left <= hold_left - 1;
    else if (!hold_done && accepted_reqs >= 300) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_o.used_count, 0);
        end else begin
          result_want = expected_results.pop_front();
          if (out_data_o.alloc_block !== result_want.alloc_block)
            report_mismatch("alloc_block", out_data_o.alloc_block, result_want.alloc_block);
          if (out_data_o.status !== result_want.status)
            report_mismatch("status", out_data_o.status, result_want.status);
          if (out_data_o.used_count !== result_want.used_count)
            report_mismatch("used_count", out_data_o.used_count, result_want.used_count);
          if (out_data_o.free_count !== result_want.free_count)
            report_mismatch("free_count", out_data_o.free_count, result_want.free_count);
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 19;
    recv_idle_pct = 86;

    // directed, limit at its reset value
    queue_req(FN_ALLOC, 0, 0);
    queue_req(FN_ALLOC, 4095, 8191);
    queue_req(FN_FREE, 0, 0);
    queue_req(FN_ALLOC, 0, 0);
    queue_req(FN_FREE_RANGE, 0, 0);
    queue_req(FN_MARK_RANGE, 0, 64);
    queue_req(FN_MARK_RANGE, 64, 64);
    queue_req(FN_ALLOC, 0, 0);           // skips two full words
    queue_req(FN_MARK_RANGE, 4000, 8191);  // runs off the end of storage
    queue_req(FN_FREE, 4095, 0);
    queue_req(FN_FREE_RANGE, 4000, 4096);
    queue_req(FN_FREE_RANGE, 0, 8191);   // counter floors at zero
    queue_req(FN_FREE, 0, 0);
    queue_req(FN_MARK_RANGE, 0, 4096);
    queue_req(FN_MARK_RANGE, 0, 8191);   // counter saturates
    queue_req(FN_ALLOC, 0, 0);           // no free count left
    queue_req(FN_FREE, 10, 0);
    queue_req(FN_FREE, 10, 0);
    queue_req(FN_MARK_RANGE, 10, 0);
    queue_req(FN_ALLOC, 0, 0);           // free count nonzero but map full
    queue_req(FN_FREE_RANGE, 0, 4096);

    run_phase(100, 60);
    run_phase(1, 30);

    send_idle_pct = 86;
    recv_idle_pct = 19;
    run_phase(0, 25);
    run_phase(8191, 80);
    run_phase(65, 60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(4096, 80);
    run_phase(64, 60);
    run_phase(200, 80);
    run_phase(4097, 30);

    wait_idle();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_map.sv
rtl/bitmap_block_allocator_top.sv
tb/tb_top.sv
